FILE: src/bsn_pkg.sv
// ----------------------------------------------------------------------------
// bsn_pkg
// Shared types, constants and codes for the biconic sag and normal block.
// ----------------------------------------------------------------------------
package bsn_pkg;

   // unsigned magnitude word, value = word / 2^32 unless noted
   typedef logic [63:0] mag_type;

   // signed working word
   typedef logic signed [63:0] sword_type;

   localparam mag_type CAP     = 64'h2000_0000_0000_0000;
   localparam mag_type ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam mag_type ONE_Q30 = 64'h0000_0000_4000_0000;

   // accept to rsp_valid, in enabled cycles
   localparam int PIPE_DEPTH = 493;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_OUT  = 2'd1,
      STATUS_EDGE = 2'd2
   } status_type;

   // register indexes
   typedef enum logic [1:0] {
      REG_CURV_X  = 2'd0,
      REG_CURV_Y  = 2'd1,
      REG_CONIC_X = 2'd2,
      REG_CONIC_Y = 2'd3
   } reg_type;

endpackage

FILE: src/biconic_sag_and_normal.sv
// ----------------------------------------------------------------------------
// biconic_sag_and_normal
// Biconic surface sag and unit normal at one point, fixed point, fully
// pipelined with a register control port for curvatures and conics.
// ----------------------------------------------------------------------------
// the delay from request accept to rsp_valid is set by the chain of root,
//   three slope divides, normal root and normal divide
// throughput: one request per cycle; a stalled result holds the whole pipeline,
//   an empty output stage lets it advance
// reset: clears all pipeline valid bits and the four registers to zero
module biconic_sag_and_normal (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_height,
   output logic signed [31:0] rsp_norm_x,
   output logic signed [31:0] rsp_norm_y,
   output logic [30:0]        rsp_norm_z,
   output logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import bsn_pkg::*;

   logic               en;
   logic [PIPE_DEPTH-1:0] vld_ff;

   logic signed [31:0] curv_x_ff, curv_y_ff, conic_x_ff, conic_y_ff;
   logic               csr_wr;
   reg_type            csr_idx;

   // per-axis values
   logic signed [31:0] pos   [2];
   logic signed [31:0] curv  [2];
   logic signed [31:0] conic [2];
   mag_type            cabs  [2];
   logic               cneg  [2];
   mag_type            k1abs [2];
   logic               k1neg [2];

   mag_type  u_ff    [2];
   mag_type  pa_ff   [2];
   logic     pneg_ff [2];
   mag_type  sq2     [2];
   mag_type  nterm   [2];
   mag_type  t2a     [2];
   mag_type  t2b     [2];
   mag_type  t2c     [2];
   mag_type  t2c_d   [2];
   mag_type  tt      [2];
   mag_type  u_d     [2];
   mag_type  t1      [2];
   mag_type  t1_d    [2];
   mag_type  t2d     [2];
   mag_type  t2e     [2];
   mag_type  t2f     [2];
   logic     pneg_d  [2];
   mag_type  mx_ff   [2];
   logic     dxneg_ff [2];
   mag_type  msq     [2];
   mag_type  mx_d    [2];
   mag_type  nm      [2];
   logic     dxneg_d [2];
   sword_type sx_t   [2];
   sword_type sx_n   [2];

   // shared values
   mag_type   nmag_ff, nmag_d1, nmag_d50;
   logic      nneg_ff, nneg_d130, nneg_d338;
   sword_type num_in, arg_in;
   sword_type arg_ff;
   logic      argneg;
   mag_type   s54, s150, s246, d54, d150;
   logic      szero_d;
   logic      argneg_d;
   mag_type   zmag;
   logic [31:0] z_in, z_ff, z_d;
   mag_type   q_ff, r394, nz490, nz_d;
   logic signed [31:0] ax_v [2];
   logic signed [31:0] nx_v [2];

   logic signed [31:0] height_in, norm_x_in, norm_y_in;
   logic [30:0]        norm_z_in;
   status_type         status_in;
   logic signed [31:0] height_ff, norm_x_ff, norm_y_ff;
   logic [30:0]        norm_z_ff;
   logic [1:0]         status_ff;

   // pipeline advances unless a finished result is held
   assign en        = !vld_ff[PIPE_DEPTH-1] || !rsp_stall;
   assign req_stall = !en;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         curv_x_ff  <= '0;
         curv_y_ff  <= '0;
         conic_x_ff <= '0;
         conic_y_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CURV_X:  curv_x_ff  <= csr_pwdata;
            REG_CURV_Y:  curv_y_ff  <= csr_pwdata;
            REG_CONIC_X: conic_x_ff <= csr_pwdata;
            REG_CONIC_Y: conic_y_ff <= csr_pwdata;
            default:     curv_x_ff  <= curv_x_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CURV_X:  csr_prdata = curv_x_ff;
         REG_CURV_Y:  csr_prdata = curv_y_ff;
         REG_CONIC_X: csr_prdata = conic_x_ff;
         REG_CONIC_Y: csr_prdata = conic_y_ff;
         default:     csr_prdata = '0;
      endcase
   end

   assign pos[0]   = req_pos_x;
   assign pos[1]   = req_pos_y;
   assign curv[0]  = curv_x_ff;
   assign curv[1]  = curv_y_ff;
   assign conic[0] = conic_x_ff;
   assign conic[1] = conic_y_ff;

   // per-axis datapath
   for (genvar a = 0; a < 2; a++) begin : g_ax
      logic [31:0]        pabs;
      logic signed [32:0] k1;
      logic [32:0]        k1m;
      sword_type          st1, st2, dx;

      // register magnitudes and signs
      assign pabs     = pos[a][31] ? 32'(-pos[a]) : 32'(pos[a]);
      assign cneg[a]  = curv[a][31];
      assign cabs[a]  = {32'd0, (curv[a][31] ? 32'(-curv[a]) : 32'(curv[a]))};
      assign k1       = {conic[a][31], conic[a]} + 33'sh100_0000;
      assign k1neg[a] = k1[32];
      assign k1m      = k1[32] ? 33'(-k1) : 33'(k1);
      assign k1abs[a] = {31'd0, k1m};

      // |c| * |p|, exact Q.46
      always_ff @(posedge clock) begin
         if (en) begin
            u_ff[a]    <= {32'd0, cabs[a][31:0]} * {32'd0, pabs};
            pa_ff[a]   <= {32'd0, pabs};
            pneg_ff[a] <= pos[a][31];
         end
      end

      // conic term and sag numerator term
      bsn_mul #(.SH(60)) u_sq  (.clock, .en, .a(u_ff[a]), .b(u_ff[a]), .r(sq2[a]));
      bsn_mul #(.SH(30)) u_nt  (.clock, .en, .a(u_ff[a]), .b(pa_ff[a]), .r(nterm[a]));
      bsn_mul #(.SH(24)) u_tt  (.clock, .en, .a(sq2[a]), .b(k1abs[a]), .r(tt[a]));

      // second slope term numerator, independent of the root
      bsn_mul #(.SH(44)) u_t2a (.clock, .en, .a(cabs[a]), .b(u_ff[a]), .r(t2a[a]));
      bsn_mul #(.SH(24)) u_t2b (.clock, .en, .a(t2a[a]), .b(k1abs[a]), .r(t2b[a]));
      bsn_mul #(.SH(32)) u_t2c (.clock, .en, .a(t2b[a]), .b(nmag_d1), .r(t2c[a]));

      bsn_dly #(.W(64), .N(47))  u_dt2c (.clock, .en, .din(t2c[a]), .dout(t2c_d[a]));
      bsn_dly #(.W(64), .N(53))  u_du   (.clock, .en, .din(u_ff[a]), .dout(u_d[a]));

      // slope divides
      bsn_div #(.SH(19)) u_t1  (.clock, .en, .num(u_d[a]), .den(d54), .quo(t1[a]));
      bsn_dly #(.W(64), .N(205)) u_dt1 (.clock, .en, .din(t1[a]), .dout(t1_d[a]));
      bsn_div #(.SH(32)) u_t2d (.clock, .en, .num(t2c_d[a]), .den(d54), .quo(t2d[a]));
      bsn_div #(.SH(32)) u_t2e (.clock, .en, .num(t2d[a]), .den(d150), .quo(t2e[a]));
      bsn_div #(.SH(32)) u_t2f (.clock, .en, .num(t2e[a]), .den(s246), .quo(t2f[a]));

      bsn_dly #(.W(1), .N(341)) u_dpn (.clock, .en, .din(pneg_ff[a]), .dout(pneg_d[a]));

      // signed slope, kept as magnitude and sign
      always_comb begin
         st1 = (cneg[a] != pneg_d[a]) ? -sword_type'(t1_d[a]) : sword_type'(t1_d[a]);
         st2 = (k1neg[a] != (pneg_d[a] != nneg_d338)) ? -sword_type'(t2f[a])
                                                      : sword_type'(t2f[a]);
         dx  = st1 + st2;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mx_ff[a]    <= dx[63] ? mag_type'(-dx) : mag_type'(dx);
            dxneg_ff[a] <= dx[63];
         end
      end

      bsn_mul #(.SH(32)) u_msq (.clock, .en, .a(mx_ff[a]), .b(mx_ff[a]), .r(msq[a]));
      bsn_dly #(.W(64), .N(147)) u_dmx (.clock, .en, .din(mx_ff[a]), .dout(mx_d[a]));
      bsn_dly #(.W(1), .N(149))  u_dsg (.clock, .en, .din(dxneg_ff[a]),
                                        .dout(dxneg_d[a]));
      bsn_mul #(.SH(32)) u_nm  (.clock, .en, .a(mx_d[a]), .b(nz490), .r(nm[a]));

      // clamp normal component and apply sign
      assign ax_v[a] = (nm[a] > ONE_Q30) ? 32'sh4000_0000 : 32'(nm[a]);
      assign nx_v[a] = dxneg_d[a] ? ax_v[a] : -ax_v[a];

      // signed terms for numerator and root argument
      assign sx_n[a] = cneg[a] ? -sword_type'(nterm[a]) : sword_type'(nterm[a]);
      assign sx_t[a] = k1neg[a] ? -sword_type'(tt[a]) : sword_type'(tt[a]);
   end

   // sag numerator
   assign num_in = sx_n[0] + sx_n[1];

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff <= num_in[63] ? mag_type'(-num_in) : mag_type'(num_in);
         nneg_ff <= num_in[63];
      end
   end

   bsn_dly #(.W(64), .N(1)) u_dnm1 (.clock, .en, .din(nmag_ff), .dout(nmag_d1));

   // root argument 1 - A
   assign arg_in = sword_type'(ONE_Q32) - (sx_t[0] + sx_t[1]);

   always_ff @(posedge clock) begin
      if (en) begin
         arg_ff <= arg_in;
      end
   end

   assign argneg = arg_ff[63];

   bsn_sqrt u_sroot (.clock, .en, .v(argneg ? '0 : mag_type'(arg_ff)), .root(s54));

   assign d54 = ONE_Q32 + s54;
   bsn_dly #(.W(64), .N(96)) u_ds1 (.clock, .en, .din(s54), .dout(s150));
   bsn_dly #(.W(64), .N(96)) u_ds2 (.clock, .en, .din(s150), .dout(s246));
   assign d150 = ONE_Q32 + s150;

   // sag
   bsn_dly #(.W(64), .N(50))  u_dnm50 (.clock, .en, .din(nmag_ff), .dout(nmag_d50));
   bsn_dly #(.W(1), .N(130))  u_dnn1  (.clock, .en, .din(nneg_ff), .dout(nneg_d130));
   bsn_dly #(.W(1), .N(338))  u_dnn2  (.clock, .en, .din(nneg_ff), .dout(nneg_d338));
   bsn_div #(.SH(16)) u_zdiv (.clock, .en, .num(nmag_d50), .den(d54), .quo(zmag));

   // saturate sag to 32 bits
   always_comb begin
      if (nneg_d130) begin
         z_in = (zmag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-zmag[31:0]);
      end else begin
         z_in = (zmag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : zmag[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff <= z_in;
      end
   end

   bsn_dly #(.W(32), .N(357)) u_dz  (.clock, .en, .din(z_ff), .dout(z_d));
   bsn_dly #(.W(1), .N(486))  u_dan (.clock, .en, .din(argneg), .dout(argneg_d));
   bsn_dly #(.W(1), .N(438))  u_dsz (.clock, .en, .din(s54 == '0), .dout(szero_d));

   // normal length and z component
   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= ONE_Q32 + msq[0] + msq[1];
      end
   end

   bsn_sqrt u_nroot (.clock, .en, .v(q_ff), .root(r394));
   bsn_div #(.SH(32)) u_nzdiv (.clock, .en, .num(ONE_Q30), .den(r394), .quo(nz490));
   bsn_dly #(.W(64), .N(2)) u_dnz (.clock, .en, .din(nz490), .dout(nz_d));

   // result select
   always_comb begin
      height_in = '0;
      norm_x_in = '0;
      norm_y_in = '0;
      norm_z_in = 31'(ONE_Q30);
      status_in = STATUS_OK;
      if (argneg_d) begin
         status_in = STATUS_OUT;
      end else if (szero_d) begin
         height_in = z_d;
         status_in = STATUS_EDGE;
      end else begin
         height_in = z_d;
         norm_x_in = nx_v[0];
         norm_y_in = nx_v[1];
         norm_z_in = nz_d[30:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         height_ff <= height_in;
         norm_x_ff <= norm_x_in;
         norm_y_ff <= norm_y_in;
         norm_z_ff <= norm_z_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = vld_ff[PIPE_DEPTH-1];
   assign rsp_height = height_ff;
   assign rsp_norm_x = norm_x_ff;
   assign rsp_norm_y = norm_y_ff;
   assign rsp_norm_z = norm_z_ff;
   assign rsp_status = status_ff;

endmodule

FILE: src/bsn_dly.sv
// ----------------------------------------------------------------------------
// bsn_dly
// Enabled shift line that keeps side values aligned with the arithmetic.
// ----------------------------------------------------------------------------
module bsn_dly #(
   parameter int W = 64,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] line_ff [N];

   // shift when the pipeline advances
   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < N; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[N-1];

endmodule

FILE: src/bsn_mul.sv
// ----------------------------------------------------------------------------
// bsn_mul
// Two-stage 64x64 multiply, truncating right shift and saturation at CAP.
// ----------------------------------------------------------------------------
module bsn_mul #(
   parameter int SH = 32
) (
   input  logic             clock,
   input  logic             en,
   input  bsn_pkg::mag_type a,
   input  bsn_pkg::mag_type b,
   output bsn_pkg::mag_type r
);
   import bsn_pkg::*;

   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] full;
   logic [127:0] shr;
   mag_type      r_in;
   mag_type      r_ff;

   // stage one: 32x32 partial products
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= a[31:0]  * b[31:0];
         p01_ff <= a[31:0]  * b[63:32];
         p10_ff <= a[63:32] * b[31:0];
         p11_ff <= a[63:32] * b[63:32];
      end
   end

   // stage two: sum, shift, saturate
   always_comb begin
      full = {64'd0, p00_ff} + ({64'd0, p01_ff} << 32) + ({64'd0, p10_ff} << 32)
           + {p11_ff, 64'd0};
      shr  = full >> SH;
      r_in = (shr > {64'd0, CAP}) ? CAP : shr[63:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

   assign r = r_ff;

endmodule

FILE: src/bsn_div.sv
// ----------------------------------------------------------------------------
// bsn_div
// Restoring divider, one quotient bit per stage: floor(n * 2^SH / d),
// saturated at CAP.
// ----------------------------------------------------------------------------
module bsn_div #(
   parameter int SH = 32
) (
   input  logic             clock,
   input  logic             en,
   input  bsn_pkg::mag_type num,
   input  bsn_pkg::mag_type den,
   output bsn_pkg::mag_type quo
);
   import bsn_pkg::*;

   localparam int N = 64 + SH;

   mag_type n_ff   [N];
   mag_type d_ff   [N];
   mag_type rem_ff [N];
   mag_type q_ff   [N];
   logic    sat_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_st
      localparam int J = N - 1 - k;
      mag_type     n_p, d_p, rem_p, q_p;
      logic        sat_p;
      logic        nbit;
      logic [64:0] rs;
      mag_type     rem_in, q_in;
      logic        sat_in;

      if (k == 0) begin : g_first
         assign n_p   = num;
         assign d_p   = den;
         assign rem_p = '0;
         assign q_p   = '0;
         assign sat_p = (den == '0);
      end else begin : g_next
         assign n_p   = n_ff[k-1];
         assign d_p   = d_ff[k-1];
         assign rem_p = rem_ff[k-1];
         assign q_p   = q_ff[k-1];
         assign sat_p = sat_ff[k-1];
      end

      // dividend bit entering at this step
      if (J >= SH) begin : g_bit
         assign nbit = n_p[J-SH];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      // compare and subtract
      always_comb begin
         rs = {rem_p, nbit};
         if (rs >= {1'b0, d_p}) begin
            rem_in = rs[63:0] - d_p;
            q_in   = {q_p[62:0], 1'b1};
         end else begin
            rem_in = rs[63:0];
            q_in   = {q_p[62:0], 1'b0};
         end
         sat_in = sat_p | (q_in > CAP);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]   <= n_p;
            d_ff[k]   <= d_p;
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            sat_ff[k] <= sat_in;
         end
      end
   end

   assign quo = sat_ff[N-1] ? CAP : q_ff[N-1];

endmodule

FILE: src/bsn_sqrt.sv
// ----------------------------------------------------------------------------
// bsn_sqrt
// Digit-by-digit floor square root of a Q.32 value, one result bit per stage.
// ----------------------------------------------------------------------------
module bsn_sqrt (
   input  logic             clock,
   input  logic             en,
   input  bsn_pkg::mag_type v,
   output bsn_pkg::mag_type root
);
   import bsn_pkg::*;

   localparam int N = 48;

   mag_type v_ff    [N];
   mag_type rem_ff  [N];
   mag_type root_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_st
      localparam int I = N - 1 - k;
      mag_type    v_p, rem_p, root_p;
      logic [1:0] pair;
      mag_type    acc, trial, rem_in, root_in;

      if (k == 0) begin : g_first
         assign v_p    = v;
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
      end

      // next two radicand bits
      if (I >= 16) begin : g_pair
         assign pair = v_p[2*I-31:2*I-32];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      // trial subtract
      always_comb begin
         acc   = {rem_p[61:0], pair};
         trial = {root_p[61:0], 2'b01};
         if (acc >= trial) begin
            rem_in  = acc - trial;
            root_in = {root_p[62:0], 1'b1};
         end else begin
            rem_in  = acc;
            root_in = {root_p[62:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k]    <= v_p;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[N-1];

endmodule

FILE: src/bsn_chk.sv
// ----------------------------------------------------------------------------
// bsn_chk
// Port-level checks on results of the biconic sag and normal block.
// ----------------------------------------------------------------------------
module bsn_chk (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_height,
   input logic signed [31:0] rsp_norm_x,
   input logic signed [31:0] rsp_norm_y,
   input logic [30:0]        rsp_norm_z,
   input logic [1:0]         rsp_status
);
   import bsn_pkg::*;

   // a held result stays valid with its height and status unchanged
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_height) && $stable(rsp_status))
      else $error("held result changed");

   // outside the domain gives zero sag and vertical normal
   a_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OUT |-> rsp_height == 0 && rsp_norm_x == 0
      && rsp_norm_y == 0 && rsp_norm_z == 31'h4000_0000)
      else $error("bad result outside domain");

   // edge case keeps a vertical normal
   a_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EDGE |-> rsp_norm_x == 0 && rsp_norm_y == 0
      && rsp_norm_z == 31'h4000_0000)
      else $error("bad normal at domain edge");

   // normal z is positive and at most one, and status is a defined code
   a_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_z != 0 && rsp_norm_z <= 31'h4000_0000
      && rsp_status != 2'd3)
      else $error("normal z or status out of range");

   // nothing comes out right after reset
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind biconic_sag_and_normal bsn_chk u_bsn_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_height (rsp_height),
   .rsp_norm_x (rsp_norm_x),
   .rsp_norm_y (rsp_norm_y),
   .rsp_norm_z (rsp_norm_z),
   .rsp_status (rsp_status)
);

FILE: dv/biconic_sag_and_normal_test.sv
// ----------------------------------------------------------------------------
// biconic_sag_and_normal_test
// Self-checking bench for the biconic sag and normal block. The register set
// goes through a series of curvature and conic settings. The fixed settings get
// directed points for the special cases, the random settings random points. A
// bit-exact model predicts every result, and both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module biconic_sag_and_normal_test;
   import bsn_pkg::*;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } point_type;

   typedef struct {
      logic signed [31:0] height;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic [30:0]        norm_z;
      status_type         status;
   } surf_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_height;
   logic signed [31:0] rsp_norm_x;
   logic signed [31:0] rsp_norm_y;
   logic [30:0]        rsp_norm_z;
   logic [1:0]         rsp_status;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [3:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   point_type          point_queue[$];
   surf_type           surface_queue[$];
   logic signed [31:0] curv_x, curv_y, kon_x, kon_y;
   bit                 jitter_on;
   bit                 hold_points;
   int                 cycle_count;
   int                 fail_count;

   biconic_sag_and_normal u_dut (.*);

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- arithmetic

   // floor(a*b / 2^sh), saturated
   function automatic mag_type mul_q(mag_type a, mag_type b, int sh);
      logic [127:0] p;
      p = ({64'b0, a} * {64'b0, b}) >> sh;
      return (p > {64'b0, CAP}) ? CAP : p[63:0];
   endfunction

   // floor(n * 2^sh / d), saturated
   function automatic mag_type div_q(mag_type n, mag_type d, int sh);
      logic [127:0] q;
      if (d == 0) return CAP;
      q = ({64'b0, n} << sh) / {64'b0, d};
      return (q > {64'b0, CAP}) ? CAP : q[63:0];
   endfunction

   // floor root of a Q.32 value at Q.32
   function automatic mag_type root_q(mag_type v);
      mag_type root, rem, trial, bits;
      root = 0;
      rem = 0;
      for (int i = 47; i >= 0; i--) begin
         bits = (i >= 16) ? ((v >> (2 * i - 32)) & 64'd3) : 64'd0;
         rem = (rem << 2) | bits;
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic mag_type mag(longint v);
      return (v < 0) ? mag_type'(-v) : mag_type'(v);
   endfunction

   function automatic longint signed_of(mag_type m, bit neg);
      longint s;
      s = longint'(m);
      return neg ? -s : s;
   endfunction

   // surface slope along one axis, signed Q.32
   function automatic longint slope_of(mag_type u, mag_type cabs, bit cneg, bit pneg,
                                       longint k1, mag_type nmag, bit nneg,
                                       mag_type s, mag_type d);
      mag_type t1, t2;
      t1 = div_q(u, d, 19);
      t2 = mul_q(cabs, u, 44);
      t2 = mul_q(t2, mag(k1), 24);
      t2 = mul_q(t2, nmag, 32);
      t2 = div_q(t2, d, 32);
      t2 = div_q(t2, d, 32);
      t2 = div_q(t2, s, 32);
      return signed_of(t1, cneg != pneg) + signed_of(t2, (k1 < 0) != (pneg != nneg));
   endfunction

   // sag and normal for one point under the current register set
   function automatic surf_type sag_at(point_type pt);
      surf_type r;
      longint   x, y, cx, cy, k1x, k1y, arg, num, z, nx, ny, dx, dy;
      mag_type  ux, uy, tx, ty, nmag, s, d, zmag, nz, mx, my, q, rt, ax, ay;
      x = pt.pos_x;
      y = pt.pos_y;
      cx = curv_x;
      cy = curv_y;
      k1x = longint'(kon_x) + (64'sd1 <<< 24);
      k1y = longint'(kon_y) + (64'sd1 <<< 24);
      ux = mag(cx) * mag(x);
      uy = mag(cy) * mag(y);
      tx = mul_q(mul_q(ux, ux, 60), mag(k1x), 24);
      ty = mul_q(mul_q(uy, uy, 60), mag(k1y), 24);
      arg = longint'(ONE_Q32) - (signed_of(tx, k1x < 0) + signed_of(ty, k1y < 0));
      num = signed_of(mul_q(ux, mag(x), 30), cx < 0) + signed_of(mul_q(uy, mag(y), 30), cy < 0);
      nmag = mag(num);
      z = 0;
      nx = 0;
      ny = 0;
      nz = ONE_Q30;
      if (arg < 0) begin
         r.status = STATUS_OUT;
      end else begin
         s = root_q(mag_type'(arg));
         d = ONE_Q32 + s;
         zmag = div_q(nmag, d, 16);
         if (num < 0) z = -longint'((zmag > 64'h8000_0000) ? 64'h8000_0000 : zmag);
         else z = longint'((zmag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : zmag);
         if (s == 0) begin
            r.status = STATUS_EDGE;
         end else begin
            r.status = STATUS_OK;
            dx = slope_of(ux, mag(cx), cx < 0, x < 0, k1x, nmag, num < 0, s, d);
            dy = slope_of(uy, mag(cy), cy < 0, y < 0, k1y, nmag, num < 0, s, d);
            mx = mag(dx);
            my = mag(dy);
            q = ONE_Q32 + mul_q(mx, mx, 32) + mul_q(my, my, 32);
            rt = root_q(q);
            nz = (64'd1 << 62) / rt;
            ax = mul_q(mx, nz, 32);
            if (ax > ONE_Q30) ax = ONE_Q30;
            ay = mul_q(my, nz, 32);
            if (ay > ONE_Q30) ay = ONE_Q30;
            nx = signed_of(ax, dx > 0);
            ny = signed_of(ay, dy > 0);
         end
      end
      r.height = z[31:0];
      r.norm_x = nx[31:0];
      r.norm_y = ny[31:0];
      r.norm_z = nz[30:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- channels

   // request driver, predicts each accepted point
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            surface_queue.push_back(sag_at(point_queue.pop_front()));
         end
         if (!(req_valid && req_stall)) begin
            if (point_queue.size() > 0 && !hold_points
                && !(jitter_on && $urandom_range(99) < 10)) begin
               req_valid <= 1'b1;
               req_pos_x <= point_queue[0].pos_x;
               req_pos_y <= point_queue[0].pos_y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and random back-pressure
   always @(posedge clock) begin
      surf_type e;
      rsp_stall <= jitter_on && ($urandom_range(99) < 10);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (surface_queue.size() == 0) begin
            $error("result with nothing expected: height %0d", rsp_height);
            fail_count++;
         end else begin
            e = surface_queue.pop_front();
            if (rsp_height !== e.height) begin
               $error("height expected %0d actual %0d", e.height, rsp_height);
               fail_count++;
            end
            if (rsp_norm_x !== e.norm_x) begin
               $error("norm_x expected %0d actual %0d", e.norm_x, rsp_norm_x);
               fail_count++;
            end
            if (rsp_norm_y !== e.norm_y) begin
               $error("norm_y expected %0d actual %0d", e.norm_y, rsp_norm_y);
               fail_count++;
            end
            if (rsp_norm_z !== e.norm_z) begin
               $error("norm_z expected %0d actual %0d", e.norm_z, rsp_norm_z);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic reg_write(reg_type idx, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_CURV_X:  curv_x = v;
         REG_CURV_Y:  curv_y = v;
         REG_CONIC_X: kon_x = v;
         REG_CONIC_Y: kon_y = v;
         default:     ;
      endcase
   endtask

   task automatic set_surface(logic [31:0] cx, logic [31:0] cy,
                              logic [31:0] kx, logic [31:0] ky);
      reg_write(REG_CURV_X, cx);
      reg_write(REG_CURV_Y, cy);
      reg_write(REG_CONIC_X, kx);
      reg_write(REG_CONIC_Y, ky);
   endtask

   task automatic add_point(logic [31:0] x, logic [31:0] y);
      point_type p;
      p.pos_x = x;
      p.pos_y = y;
      point_queue.push_back(p);
   endtask

   task automatic wait_drained();
      while (point_queue.size() > 0 || surface_queue.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   // random point: mostly inside a few units of the axis, some raw words
   task automatic add_random_points(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 75)
            add_point($signed($urandom_range(1 << 20)) - (1 << 19),
                      $signed($urandom_range(1 << 20)) - (1 << 19));
         else if (k < 88)
            add_point($urandom, $urandom);
         else
            add_point($signed($urandom_range(512)) - 256, $signed($urandom_range(512)) - 256);
      end
   endtask

   initial begin
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      curv_x = '0;
      curv_y = '0;
      kon_x = '0;
      kon_y = '0;
      jitter_on = 1'b1;
      hold_points = 1'b0;
      cycle_count = 0;
      fail_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // flat surface after reset, extreme coordinates
      add_point(32'sh7FFF_FFFF, 32'sh8000_0000);
      add_point(32'sh8000_0000, 32'sh7FFF_FFFF);
      add_point(0, 0);
      add_point(-1, 1);
      wait_drained();

      // unit sphere: axis, edge of the domain, outside it
      set_surface(32'h4000_0000, 32'h4000_0000, 0, 0);
      add_point(32'h0001_0000, 0);
      add_point(-32'sh0001_0000, 0);
      add_point(0, 32'h0000_8000);
      add_point(32'h0000_4000, -32'sh0000_4000);
      add_point(32'h0001_0001, 0);
      add_point(32'sh7FFF_FFFF, 32'sh8000_0000);
      wait_drained();

      // concave sphere, also at its edge
      set_surface(32'hC000_0000, 32'hE000_0000, 0, 0);
      add_point(-32'sh0001_0000, 0);
      add_point(32'h0000_8000, 32'h0000_8000);
      wait_drained();

      // extreme curvatures and conics, tiny points
      set_surface(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      add_point(1, -1);
      add_point(32'h0000_0100, 32'h0000_0100);
      add_point(-32'sh0000_0100, 0);
      wait_drained();

      // paraboloid with huge points: saturated height
      set_surface(32'h0010_0000, 32'hFFF0_0000, 32'hFF00_0000, 32'hFF00_0000);
      add_point(32'sh7FFF_FFFF, 0);
      add_point(0, 32'sh7FFF_FFFF);
      add_point(32'sh8000_0000, 32'sh8000_0000);
      add_point(32'h0100_0000, 32'h0000_0010);
      wait_drained();

      // random settings with random points
      for (int ph = 0; ph < 8; ph++) begin
         pick = $urandom_range(9);
         if (pick < 6)
            set_surface($signed($urandom_range(1 << 28)) - (1 << 27),
                        $signed($urandom_range(1 << 28)) - (1 << 27),
                        $signed($urandom_range(1 << 27)) - (1 << 26),
                        $signed($urandom_range(1 << 27)) - (1 << 26));
         else if (pick < 8)
            set_surface($signed($urandom_range(1 << 28)) - (1 << 27),
                        $signed($urandom_range(1 << 28)) - (1 << 27),
                        32'hFF00_0000, 32'hFF00_0000);
         else
            set_surface($urandom, $urandom, $urandom, $urandom);
         jitter_on = (ph != 3);
         add_random_points(75);
         // sender holds off until the pipeline is empty
         if (ph == 5) begin
            hold_points = 1'b1;
            while (surface_queue.size() > 0 || req_valid) @(posedge clock);
            hold_points = 1'b0;
         end
         add_random_points(75);
         wait_drained();
      end

      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (fail_count == 0 && surface_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
src/bsn_pkg.sv
src/bsn_dly.sv
src/bsn_mul.sv
src/bsn_div.sv
src/bsn_sqrt.sv
src/biconic_sag_and_normal.sv
src/bsn_chk.sv
dv/biconic_sag_and_normal_test.sv
